[rtl/pdac_pkg.sv]
// Shared package for the PWM duty angle capture block.
// Holds field widths, reset values, register indexes, controller states
// and the command and status structs. Depends on nothing.
package pdac_pkg;

    // Field widths fixed by the interface.
    localparam int TIME_W     = 32;
    localparam int PERMILLE_W = 10;
    localparam int PROD_W     = TIME_W + PERMILLE_W;
    localparam int CFG_IDX_W  = 1;

    // Defaults for the top level parameters.
    localparam int NUM_CHANNELS_DEF = 2;
    localparam int ANGLE_BITS_DEF   = 12;

    // Duty limits in thousandths.
    localparam logic [PERMILLE_W-1:0] PERMILLE_FULL  = 10'd1000;
    localparam logic [PERMILLE_W-1:0] DUTY_MIN_RESET = 10'd10;
    localparam logic [PERMILLE_W-1:0] DUTY_MAX_RESET = 10'd990;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic mul;
        logic sub;
        logic load;
        logic div_step;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_result;
        logic out_free;
    } status_t;

endpackage

[rtl/pdac_ctrl.sv]
// Controller state machine for the PWM duty angle capture block.
// Sequences capture, multiply, subtract, divider load, divider steps and emit.
// Depends on pdac_pkg.
module pdac_ctrl #(
    parameter int ANGLE_BITS = pdac_pkg::ANGLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pdac_pkg::status_t st,
    output pdac_pkg::cmd_t    cmd
);

    localparam int CNT_W = $clog2(ANGLE_BITS);

    pdac_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdac_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            pdac_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid && st.item_result)
                begin
                    state_next = pdac_pkg::ST_MUL;
                end
            end
            pdac_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = pdac_pkg::ST_SUB;
            end
            pdac_pkg::ST_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = pdac_pkg::ST_LOAD;
            end
            pdac_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                cnt_next   = CNT_W'(ANGLE_BITS - 1);
                state_next = pdac_pkg::ST_DIV;
            end
            pdac_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = pdac_pkg::ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            pdac_pkg::ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = pdac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pdac_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/pdac_dp.sv]
// Datapath for the PWM duty angle capture block: per-channel edge times,
// duty limits, multipliers, restoring divider and the output register.
// Depends on pdac_pkg.
module pdac_dp #(
    parameter int NUM_CHANNELS = pdac_pkg::NUM_CHANNELS_DEF,
    parameter int ANGLE_BITS   = pdac_pkg::ANGLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pdac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdac_pkg::PERMILLE_W-1:0]     cfg_wdata,
    input  logic                                sensor_channel,
    input  logic                                edge_rising,
    input  logic [pdac_pkg::TIME_W-1:0]         edge_time,
    input  pdac_pkg::cmd_t                      cmd,
    output pdac_pkg::status_t                   st,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic                                result_channel,
    output logic [ANGLE_BITS-1:0]               angle_code,
    output logic                                period_error
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PW     = pdac_pkg::PROD_W;
    localparam int DVD_W  = PW + ANGLE_BITS;
    localparam logic [ANGLE_BITS-1:0] FULL = {ANGLE_BITS{1'b1}};

    // Per-channel state, shared configuration and the output valid flag.
    logic [pdac_pkg::TIME_W-1:0]     last_rise_reg [NUM_CHANNELS];
    logic [pdac_pkg::TIME_W-1:0]     high_time_reg [NUM_CHANNELS];
    logic [pdac_pkg::PERMILLE_W-1:0] duty_min_reg, duty_max_reg;
    logic                            out_valid_reg;

    // Working registers.
    logic                            ch_reg;
    logic [pdac_pkg::TIME_W-1:0]     period_reg, high_reg;
    logic [PW-1:0]                   pos_reg, neg_reg, den_reg, num_reg, rem_reg;
    logic                            err_reg, zero_reg, sat_reg;
    logic [ANGLE_BITS-1:0]           low_reg, q_reg;
    logic                            res_ch_reg, res_err_reg;
    logic [ANGLE_BITS-1:0]           res_angle_reg;

    logic [CH_W-1:0]                 ch_idx;
    logic                            ch_ok;
    logic [pdac_pkg::TIME_W-1:0]     delta;
    logic [pdac_pkg::PERMILLE_W-1:0] span;
    logic [DVD_W-1:0]                dvd;
    logic [PW:0]                     trial;
    logic                            ge;

    // Channel decode and the time since the channel's last rise.
    assign ch_idx = CH_W'(sensor_channel);
    assign ch_ok  = (NUM_CHANNELS > 1) || !sensor_channel;
    assign delta  = edge_time - last_rise_reg[ch_idx];
    assign span   = duty_max_reg - duty_min_reg;

    // Scaled dividend num * FULL, formed as a shift and a subtract.
    assign dvd = {num_reg, {ANGLE_BITS{1'b0}}} - DVD_W'(num_reg);

    // One restoring division step.
    assign trial = {rem_reg, low_reg[ANGLE_BITS-1]};
    assign ge    = trial >= {1'b0, den_reg};

    assign st.item_result = ch_ok && edge_rising;
    assign st.out_free    = !out_valid_reg || out_ready;

    // Control state: channel times, limits and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                last_rise_reg[i] <= '0;
                high_time_reg[i] <= '0;
            end
            duty_min_reg  <= pdac_pkg::DUTY_MIN_RESET;
            duty_max_reg  <= pdac_pkg::DUTY_MAX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pdac_pkg::REG_DUTY_MIN)
                begin
                    duty_min_reg <= cfg_wdata;
                end
                else if (cfg_index == pdac_pkg::REG_DUTY_MAX)
                begin
                    duty_max_reg <= cfg_wdata;
                end
            end
            if (cmd.capture && ch_ok)
            begin
                if (edge_rising)
                begin
                    last_rise_reg[ch_idx] <= edge_time;
                end
                else
                begin
                    high_time_reg[ch_idx] <= delta;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic pipeline and result word.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg     <= sensor_channel;
            period_reg <= delta;
            high_reg   <= high_time_reg[ch_idx];
        end
        if (cmd.mul)
        begin
            pos_reg <= PW'(high_reg) * PW'(pdac_pkg::PERMILLE_FULL);
            neg_reg <= PW'(duty_min_reg) * PW'(period_reg);
            den_reg <= PW'(span) * PW'(period_reg);
            err_reg <= (period_reg == '0) || (duty_max_reg <= duty_min_reg);
        end
        if (cmd.sub)
        begin
            num_reg  <= pos_reg - neg_reg;
            zero_reg <= err_reg || (pos_reg <= neg_reg);
        end
        if (cmd.load)
        begin
            // Duty at or above the upper limit saturates.
            sat_reg <= num_reg >= den_reg;
            rem_reg <= dvd[DVD_W-1:ANGLE_BITS];
            low_reg <= dvd[ANGLE_BITS-1:0];
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? PW'(trial - {1'b0, den_reg}) : trial[PW-1:0];
            low_reg <= low_reg << 1;
            q_reg   <= {q_reg[ANGLE_BITS-2:0], ge};
        end
        if (cmd.emit)
        begin
            res_ch_reg    <= ch_reg;
            res_err_reg   <= err_reg;
            res_angle_reg <= zero_reg ? '0 : (sat_reg ? FULL : q_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_channel = res_ch_reg;
    assign angle_code     = res_angle_reg;
    assign period_error   = res_err_reg;

endmodule

[rtl/pwm_duty_angle_capture.sv]
// Top level of the PWM duty angle capture block.
// Joins the controller and the datapath. Depends on pdac_pkg, pdac_ctrl, pdac_dp.
//
//  Channel   Direction  Fields
//  s_axis    in         tdata: edge_time; tuser: sensor_channel, edge_rising
//  m_axis    out        tdata: angle_code; tuser: result_channel, period_error
//  cfg       in         index 0 duty_min_permille, index 1 duty_max_permille
//
// A falling edge is taken in the idle state. A rising edge runs multiply,
// subtract, load, divide, emit; the bit-serial restoring divider yields one
// angle bit a cycle. One word is in work at a time; a finished word waits in
// the output register while the next edge is taken. Reset clears the channel
// times to zero and loads the duty limits; it needs no clearing pass.
module pwm_duty_angle_capture #(
    parameter int NUM_CHANNELS = pdac_pkg::NUM_CHANNELS_DEF,
    parameter int ANGLE_BITS   = pdac_pkg::ANGLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pdac_pkg::TIME_W-1:0]         s_axis_tdata,  // edge_time
    input  logic [1:0]                          s_axis_tuser,  // sensor_channel, edge_rising
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((ANGLE_BITS+7)/8)*8-1:0]     m_axis_tdata,  // angle_code
    output logic [1:0]                          m_axis_tuser,  // result_channel, period_error
    input  logic                                cfg_we,
    input  logic [pdac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdac_pkg::PERMILLE_W-1:0]     cfg_wdata
);

    localparam int OUT_W = ((ANGLE_BITS + 7) / 8) * 8;

    pdac_pkg::cmd_t    cmd;
    pdac_pkg::status_t st;
    logic                  res_ch, res_err;
    logic [ANGLE_BITS-1:0] res_angle;

    pdac_ctrl #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pdac_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .sensor_channel (s_axis_tuser[0]),
        .edge_rising    (s_axis_tuser[1]),
        .edge_time      (s_axis_tdata),
        .cmd            (cmd),
        .st             (st),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .result_channel (res_ch),
        .angle_code     (res_angle),
        .period_error   (res_err)
    );

    assign m_axis_tdata = OUT_W'(res_angle);
    assign m_axis_tuser = {res_err, res_ch};

    // An error result always reports a zero angle.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero angle");

    // A new word is only loaded when the output register is free.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result word overwritten");

    // A falling edge produces no result.
    a_fall_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser[1]) |=> !cmd.emit)
        else $error("falling edge started a result");

endmodule

[test/tb_pwm_duty_angle_capture.sv]
// Testbench for pwm_duty_angle_capture: drives captured edges, predicts angle words
// and checks them field by field. Depends on pdac_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_pwm_duty_angle_capture;

    localparam int ANGLE_BITS    = pdac_pkg::ANGLE_BITS_DEF;
    localparam int ANGLE_FULL    = (1 << ANGLE_BITS) - 1;
    localparam int SETTLE_CYCLES = ANGLE_BITS + 5 + 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_EDGES   = 85;
    localparam int NUM_PHASES    = 8;
    localparam int NUM_ROWS      = 15;

    // One expected angle word.
    typedef struct packed {
        logic                  chan;
        logic [ANGLE_BITS-1:0] angle;
        logic                  err;
    } angle_word_t;

    // One directed edge, with a typed expectation where it is obvious.
    typedef struct {
        logic          chan;
        logic          rising;
        logic [31:0]   stamp;
        logic          typed;
        angle_word_t   want;
    } edge_row_t;

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [pdac_pkg::TIME_W-1:0]          s_axis_tdata  = '0;
    logic [1:0]                           s_axis_tuser  = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [((ANGLE_BITS+7)/8)*8-1:0]      m_axis_tdata;
    logic [1:0]                           m_axis_tuser;
    logic                                 cfg_we        = 1'b0;
    logic [pdac_pkg::CFG_IDX_W-1:0]       cfg_index     = '0;
    logic [pdac_pkg::PERMILLE_W-1:0]      cfg_wdata     = '0;

    // Predictor state: per channel rise stamps and high spans, and the duty limits.
    logic [31:0]                     rise_stamp [2];
    logic [31:0]                     high_span  [2];
    logic [pdac_pkg::PERMILLE_W-1:0] lim_min;
    logic [pdac_pkg::PERMILLE_W-1:0] lim_max;

    angle_word_t pending_angles [$];
    angle_word_t head_word;
    int          fail_count  = 0;
    int          cycle_count = 0;
    logic        send_quiet  = 1'b0;
    logic        take_quiet  = 1'b0;

    // Duty limits per phase; the sixth phase draws random limits.
    logic [pdac_pkg::PERMILLE_W-1:0] phase_min [NUM_PHASES] = '{10'd0, 10'd1000, 10'd0,
                                                               10'd1023, 10'd500, 10'd0,
                                                               10'd250, 10'd10};
    logic [pdac_pkg::PERMILLE_W-1:0] phase_max [NUM_PHASES] = '{10'd1000, 10'd0, 10'd1023,
                                                               10'd1023, 10'd501, 10'd0,
                                                               10'd750, 10'd990};

    // Directed edges under the reset limits of 10 and 990 thousandths.
    edge_row_t directed_rows [NUM_ROWS] = '{
        // First rise after reset: period from zero is zero.
        '{1'b0, 1'b1, 32'd0,          1'b1, '{1'b0, 12'd0,    1'b1}},
        '{1'b1, 1'b1, 32'd0,          1'b1, '{1'b1, 12'd0,    1'b1}},
        // Half duty.
        '{1'b0, 1'b0, 32'd500,        1'b0, '0},
        '{1'b0, 1'b1, 32'd1000,       1'b0, '0},
        // High time longer than the period saturates.
        '{1'b0, 1'b0, 32'd3000,       1'b0, '0},
        '{1'b0, 1'b1, 32'd2000,       1'b1, '{1'b0, 12'd4095, 1'b0}},
        // Largest timestamps, full duty.
        '{1'b1, 1'b0, 32'hFFFF_FFFF,  1'b0, '0},
        '{1'b1, 1'b1, 32'hFFFF_FFFF,  1'b1, '{1'b1, 12'd4095, 1'b0}},
        // Timer wrap between rise and fall.
        '{1'b1, 1'b0, 32'd4,          1'b0, '0},
        '{1'b1, 1'b1, 32'd9,          1'b0, '0},
        // Repeated rise at the same time gives a zero period.
        '{1'b0, 1'b1, 32'd2000,       1'b1, '{1'b0, 12'd0,    1'b1}},
        // Duty below the minimum clamps to zero.
        '{1'b0, 1'b0, 32'd2001,       1'b0, '0},
        '{1'b0, 1'b1, 32'd102000,     1'b1, '{1'b0, 12'd0,    1'b0}},
        '{1'b1, 1'b0, 32'h5555_5555,  1'b0, '0},
        '{1'b1, 1'b1, 32'hAAAA_AAAA,  1'b0, '0}
    };

    pwm_duty_angle_capture i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Maps the duty high/period onto the angle range between the limits.
    function automatic logic [ANGLE_BITS-1:0] angle_of(input logic [31:0] high,
                                                        input logic [31:0] period,
                                                        output logic err);
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] quot;
        if (period == 32'd0 || lim_max <= lim_min) begin
            err = 1'b1;
            return '0;
        end
        err = 1'b0;
        pos = 64'(high) * 64'd1000;
        neg = 64'(lim_min) * 64'(period);
        if (pos <= neg)
            return '0;
        quot = ((pos - neg) * 64'(ANGLE_FULL)) / (64'(lim_max - lim_min) * 64'(period));
        if (quot > 64'(ANGLE_FULL))
            quot = 64'(ANGLE_FULL);
        return quot[ANGLE_BITS-1:0];
    endfunction

    // Presents one edge word, waits for it to be taken and, for a rising edge, predicts its angle word.
    task automatic send_edge(input logic chan, input logic rising, input logic [31:0] stamp,
                             input logic typed, input angle_word_t typed_word);
        int          gap;
        logic [31:0] period;
        logic        err;
        angle_word_t word;
        if ($urandom_range(0, 15) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        s_axis_tuser  <= {rising, chan};
        do @(posedge clk); while (!s_axis_tready);
        if (rising)
        begin
            period           = stamp - rise_stamp[chan];
            rise_stamp[chan] = stamp;
            word.chan        = chan;
            word.angle       = angle_of(high_span[chan], period, err);
            word.err         = err;
            pending_angles.push_back(typed ? typed_word : word);
        end
        else
        begin
            high_span[chan] = stamp - rise_stamp[chan];
        end
    endtask

    // Waits until every expected word is out and the block has had time to finish.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one duty limit register while the block is idle.
    task automatic write_limit(input logic [pdac_pkg::CFG_IDX_W-1:0] index,
                               input logic [pdac_pkg::PERMILLE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (index == pdac_pkg::REG_DUTY_MIN)
            lim_min = value;
        else
            lim_max = value;
    endtask

    // Random edges: mostly whole PWM periods, a fall then a rise, with random period and duty, some noise.
    task automatic run_pwm_phase(input int num_edges);
        int          sent;
        int          pick;
        logic        chan;
        logic [31:0] period;
        logic [31:0] high;
        logic [63:0] span;
        sent = 0;
        while (sent < num_edges)
        begin
            chan = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 8)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    period = 32'd0;
                else if (pick == 1)
                    period = $urandom;
                else
                    period = $urandom_range(1, 5000);
                pick = $urandom_range(0, 1100);
                span = (64'(period) * 64'(pick)) / 64'd1000;
                high = (pick > 1080) ? $urandom : span[31:0];
                send_edge(chan, 1'b0, rise_stamp[chan] + high, 1'b0, '0);
                send_edge(chan, 1'b1, rise_stamp[chan] + period, 1'b0, '0);
                sent += 2;
            end
            else
            begin
                send_edge(chan, 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 1) == 1) ? $urandom
                                                      : rise_stamp[chan] + $urandom_range(0, 99),
                          1'b0, '0);
                sent += 1;
            end
        end
    endtask

    // Sink side: random stalls per word, with quiet stretches.
    initial
    begin
        int stall;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                take_quiet = !take_quiet;
            stall = take_quiet ? 0 : $urandom_range(0, 17);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Compares each accepted angle word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_angles.size() == 0)
            begin
                $error("unexpected angle word: channel %0d angle %0d error %0d",
                       m_axis_tuser[0], m_axis_tdata[ANGLE_BITS-1:0], m_axis_tuser[1]);
                fail_count++;
            end
            else
            begin
                head_word = pending_angles.pop_front();
                if (m_axis_tuser[0] !== head_word.chan)
                begin
                    $error("result_channel: expected %0d, got %0d",
                           head_word.chan, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tdata[ANGLE_BITS-1:0] !== head_word.angle)
                begin
                    $error("angle_code: expected %0d, got %0d",
                           head_word.angle, m_axis_tdata[ANGLE_BITS-1:0]);
                    fail_count++;
                end
                if (m_axis_tuser[1] !== head_word.err)
                begin
                    $error("period_error: expected %0d, got %0d",
                           head_word.err, m_axis_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed edges, then random phases over several limit settings.
    initial
    begin
        rise_stamp = '{32'd0, 32'd0};
        high_span  = '{32'd0, 32'd0};
        lim_min    = pdac_pkg::DUTY_MIN_RESET;
        lim_max    = pdac_pkg::DUTY_MAX_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < NUM_ROWS; row++)
            send_edge(directed_rows[row].chan, directed_rows[row].rising,
                      directed_rows[row].stamp, directed_rows[row].typed,
                      directed_rows[row].want);
        drain_block();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 5)
            begin
                write_limit(pdac_pkg::REG_DUTY_MIN, 10'($urandom_range(0, 1023)));
                write_limit(pdac_pkg::REG_DUTY_MAX, 10'($urandom_range(0, 1023)));
            end
            else
            begin
                write_limit(pdac_pkg::REG_DUTY_MIN, phase_min[phase]);
                write_limit(pdac_pkg::REG_DUTY_MAX, phase_max[phase]);
            end
            run_pwm_phase(PHASE_EDGES);
            drain_block();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/pdac_pkg.sv
rtl/pdac_ctrl.sv
rtl/pdac_dp.sv
rtl/pwm_duty_angle_capture.sv
test/tb_pwm_duty_angle_capture.sv
